/* rtl/assert_macros.svh */
// assertion helpers used by the top rtl file
// every macro samples on clk and is off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every active clock edge
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/apfp_pkg.sv */
`default_nettype none

package apfp_pkg;

  // frame characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // limits
  localparam int          VALUE_CHARS = 31;
  localparam int          CNT_W       = $clog2(VALUE_CHARS + 1);
  localparam int          FRAC_DIGITS = 9;
  localparam int          FRAC_BITS   = 16;
  localparam logic [15:0] ID_MAX      = 16'hFFFF;
  localparam logic [30:0] WHOLE_MAX   = 31'h7FFF_FFFF;
  localparam logic [47:0] VALUE_MAX   = 48'h7FFF_FFFF_FFFF;

  // fraction is scaled to nine digits, then divided by 10^9 with rounding;
  // floor(2^(FRAC_BITS + 45) / 10^9) gives a quotient estimate that is short
  // by at most two, fixed up from the low 32 bits of the remainder
  localparam logic [31:0] DEC_ONE   = 32'd1000000000;
  localparam logic [31:0] DEC_TWO   = 32'd2000000000;
  localparam logic [31:0] DEC_HALF  = 32'd500000000;
  localparam logic [31:0] REC_MUL   = 32'd2305843009;
  localparam int          REC_SHIFT = 45;

  // frame fields that travel with every result
  typedef struct packed {
    logic [15:0] id;
    logic        neg;
    logic [30:0] whole;
    logic        ok;
  } meta_t;

  // finished frame from the parser
  typedef struct packed {
    meta_t       meta;
    logic [29:0] frac_acc;
    logic [3:0]  frac_digits;
  } pkt_t;

  // frame with its binary fraction
  typedef struct packed {
    meta_t       meta;
    logic [16:0] frac;
  } res_t;

  // 10^(9 - digits): brings the fraction text to nine digits
  function automatic logic [29:0] frac_scale(input logic [3:0] digits);
    logic [29:0] scale;
    case (digits)
      4'd0:    scale = 30'd1000000000;
      4'd1:    scale = 30'd100000000;
      4'd2:    scale = 30'd10000000;
      4'd3:    scale = 30'd1000000;
      4'd4:    scale = 30'd100000;
      4'd5:    scale = 30'd10000;
      4'd6:    scale = 30'd1000;
      4'd7:    scale = 30'd100;
      4'd8:    scale = 30'd10;
      default: scale = 30'd1;
    endcase
    return scale;
  endfunction

endpackage

`default_nettype wire

/* rtl/apfp_in_if.sv */
`default_nettype none

interface apfp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/apfp_out_if.sv */
`default_nettype none

interface apfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] param_id;
  logic [47:0] param_value;
  logic        parse_ok;

  modport source (output valid, output param_id, output param_value, output parse_ok,
                  input ready);
  modport sink (input valid, input param_id, input param_value, input parse_ok,
                output ready);
endinterface

`default_nettype wire

/* rtl/apfp_parser.sv */
`default_nettype none

module apfp_parser (
  input  logic              clk,
  input  logic              rst,
  apfp_in_if.sink           byte_ch,
  output logic              pkt_valid,
  input  logic              pkt_ready,
  output apfp_pkg::pkt_t    pkt
);

  // frame phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HASH   = 3'd1;
  localparam logic [2:0] PH_LETTER = 3'd2;
  localparam logic [2:0] PH_ID     = 3'd3;
  localparam logic [2:0] PH_VALUE  = 3'd4;

  // number phase codes
  localparam logic [2:0] NP_START = 3'd0;
  localparam logic [2:0] NP_SIGN  = 3'd1;
  localparam logic [2:0] NP_WHOLE = 3'd2;
  localparam logic [2:0] NP_FRAC  = 3'd3;
  localparam logic [2:0] NP_TRAIL = 3'd4;
  localparam logic [2:0] NP_BAD   = 3'd5;

  typedef struct packed {
    logic [apfp_pkg::CNT_W-1:0] char_count;
    logic [2:0]                 number_phase;
    logic                       is_negative;
    logic                       seen_digit;
    logic [30:0]                whole_acc;
    logic [29:0]                fraction_acc;
    logic [3:0]                 fraction_digits;
  } num_t;

  localparam num_t NUM_CLEAR = '0;

  logic [2:0]  frame_phase;
  logic [2:0]  frame_phase_next;
  logic [15:0] frame_number;
  logic [15:0] frame_number_next;
  num_t        num;
  num_t        num_next;

  logic        digit;
  logic        blank;
  logic [3:0]  dval;
  logic [19:0] id_calc;
  logic [34:0] whole_calc;
  logic [33:0] frac_calc;
  logic        restart;

  // a frame result leaves on the closing character
  assign pkt_valid = byte_ch.valid && !byte_ch.req_type && (frame_phase == PH_VALUE) &&
                     (byte_ch.rx_byte == apfp_pkg::CH_BANG);
  assign byte_ch.ready = pkt_ready;

  assign pkt.meta.id       = frame_number;
  assign pkt.meta.neg      = num.is_negative;
  assign pkt.meta.whole    = num.whole_acc;
  assign pkt.meta.ok       = num.seen_digit && (num.number_phase <= NP_TRAIL);
  assign pkt.frac_acc      = num.fraction_acc;
  assign pkt.frac_digits   = num.fraction_digits;

  // character classes and decimal accumulators
  always_comb begin
    digit = byte_ch.rx_byte inside {[apfp_pkg::CH_ZERO:apfp_pkg::CH_NINE]};
    blank = byte_ch.rx_byte inside {apfp_pkg::CH_CR, apfp_pkg::CH_LF, apfp_pkg::CH_SPACE};
    dval  = digit ? byte_ch.rx_byte[3:0] : 4'd0;
    id_calc    = {1'b0, frame_number, 3'b000} + {3'b000, frame_number, 1'b0} + 20'(dval);
    whole_calc = {1'b0, num.whole_acc, 3'b000} + {3'b000, num.whole_acc, 1'b0} + 35'(dval);
    frac_calc  = {1'b0, num.fraction_acc, 3'b000} + {3'b000, num.fraction_acc, 1'b0} +
                 34'(dval);
  end

  // frame and number state update
  always_comb begin
    frame_phase_next  = frame_phase;
    frame_number_next = frame_number;
    num_next          = num;
    restart           = 1'b0;
    if (byte_ch.valid && pkt_ready) begin
      if (byte_ch.req_type) begin
        restart = 1'b1;
      end else begin
        case (frame_phase)
          PH_IDLE: begin
            if (byte_ch.rx_byte == apfp_pkg::CH_HASH) frame_phase_next = PH_HASH;
          end
          PH_HASH: begin
            if (byte_ch.rx_byte == apfp_pkg::CH_P) begin
              frame_phase_next  = PH_LETTER;
              frame_number_next = '0;
            end else begin
              restart = 1'b1;
            end
          end
          PH_LETTER, PH_ID: begin
            if (digit) begin
              frame_number_next = (id_calc > 20'(apfp_pkg::ID_MAX)) ? apfp_pkg::ID_MAX :
                                  id_calc[15:0];
              frame_phase_next  = PH_ID;
            end else if (byte_ch.rx_byte == apfp_pkg::CH_EQ) begin
              frame_phase_next = PH_VALUE;
              num_next         = NUM_CLEAR;
            end else begin
              restart = 1'b1;
            end
          end
          PH_VALUE: begin
            if (byte_ch.rx_byte == apfp_pkg::CH_BANG) begin
              restart = 1'b1;
            end else if (num.char_count <
                         apfp_pkg::CNT_W'(apfp_pkg::VALUE_CHARS)) begin
              num_next.char_count = num.char_count + apfp_pkg::CNT_W'(1);
              // value text checker
              if (num.number_phase > NP_TRAIL) begin
                num_next.number_phase = NP_BAD;
              end else if (num.number_phase == NP_TRAIL) begin
                if (!blank) num_next.number_phase = NP_BAD;
              end else if (blank) begin
                num_next.number_phase = NP_TRAIL;
              end else if (num.number_phase == NP_FRAC) begin
                if (digit) begin
                  num_next.seen_digit = 1'b1;
                  if (num.fraction_digits < 4'(apfp_pkg::FRAC_DIGITS)) begin
                    num_next.fraction_acc    = frac_calc[29:0];
                    num_next.fraction_digits = num.fraction_digits + 4'd1;
                  end
                end else begin
                  num_next.number_phase = NP_BAD;
                end
              end else if (digit) begin
                num_next.whole_acc    = (whole_calc > 35'(apfp_pkg::WHOLE_MAX)) ?
                                        apfp_pkg::WHOLE_MAX : whole_calc[30:0];
                num_next.seen_digit   = 1'b1;
                num_next.number_phase = NP_WHOLE;
              end else if (byte_ch.rx_byte == apfp_pkg::CH_DOT) begin
                num_next.number_phase = NP_FRAC;
              end else if ((byte_ch.rx_byte == apfp_pkg::CH_MINUS) &&
                           (num.number_phase == NP_START)) begin
                num_next.is_negative  = 1'b1;
                num_next.number_phase = NP_SIGN;
              end else begin
                num_next.number_phase = NP_BAD;
              end
            end else begin
              restart = 1'b1;
            end
          end
          default: restart = 1'b1;
        endcase
      end
    end
    if (restart) begin
      frame_phase_next  = PH_IDLE;
      frame_number_next = '0;
      num_next          = NUM_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase  <= PH_IDLE;
      frame_number <= '0;
      num          <= NUM_CLEAR;
    end else begin
      frame_phase  <= frame_phase_next;
      frame_number <= frame_number_next;
      num          <= num_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/apfp_frac.sv */
`default_nettype none

module apfp_frac (
  input  logic              clk,
  input  logic              rst,
  input  logic              pkt_valid,
  output logic              pkt_ready,
  input  apfp_pkg::pkt_t    pkt,
  output logic              res_valid,
  input  logic              res_ready,
  output apfp_pkg::res_t    res
);

  logic              s0_valid;
  apfp_pkg::pkt_t    s0_pkt;
  logic              s0_en;
  logic              s1_valid;
  apfp_pkg::meta_t   s1_meta;
  logic [29:0]       s1_acc9;
  logic              s1_en;
  logic              s2_valid;
  apfp_pkg::meta_t   s2_meta;
  logic [15:0]       s2_acc_lo;
  logic [16:0]       s2_q;
  logic              s2_en;
  logic              s3_valid;
  apfp_pkg::meta_t   s3_meta;
  logic [31:0]       s3_num;
  logic [31:0]       s3_sub;
  logic [16:0]       s3_q;
  logic              s3_en;
  logic              s4_valid;
  apfp_pkg::res_t    s4_res;
  logic              s4_en;
  logic [59:0]       prod;
  logic [61:0]       est;
  logic [31:0]       rem;
  logic [16:0]       q_fix;

  // stage advance: a stage moves when empty or when the next one moves
  assign s4_en = !s4_valid || res_ready;
  assign s3_en = !s3_valid || s4_en;
  assign s2_en = !s2_valid || s3_en;
  assign s1_en = !s1_valid || s2_en;
  assign s0_en = !s0_valid || s1_en;

  assign pkt_ready = s0_en;

  // scale the fraction text to nine digits
  assign prod = s0_pkt.frac_acc * apfp_pkg::frac_scale(s0_pkt.frac_digits);

  // quotient estimate by reciprocal multiply, never above the true quotient
  assign est = s1_acc9 * apfp_pkg::REC_MUL;

  // remainder fix-up: the estimate is short by zero, one or two
  always_comb begin
    rem = s3_num - s3_sub;
    if (rem >= apfp_pkg::DEC_TWO) begin
      q_fix = s3_q + 17'd2;
    end else if (rem >= apfp_pkg::DEC_ONE) begin
      q_fix = s3_q + 17'd1;
    end else begin
      q_fix = s3_q;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s0_en) s0_valid <= pkt_valid;
      if (s1_en) s1_valid <= s0_valid;
      if (s2_en) s2_valid <= s1_valid;
      if (s3_en) s3_valid <= s2_valid;
      if (s4_en) s4_valid <= s3_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (s0_en) s0_pkt <= pkt;
    if (s1_en) begin
      s1_meta <= s0_pkt.meta;
      s1_acc9 <= prod[29:0];
    end
    if (s2_en) begin
      s2_meta   <= s1_meta;
      s2_acc_lo <= s1_acc9[15:0];
      s2_q      <= est[apfp_pkg::REC_SHIFT+16:apfp_pkg::REC_SHIFT];
    end
    // low 32 bits of numerator and of estimate times 10^9
    if (s3_en) begin
      s3_meta <= s2_meta;
      s3_num  <= {s2_acc_lo, 16'h0000} + apfp_pkg::DEC_HALF;
      s3_sub  <= {15'b0, s2_q} * apfp_pkg::DEC_ONE;
      s3_q    <= s2_q;
    end
    if (s4_en) begin
      s4_res.meta <= s3_meta;
      s4_res.frac <= q_fix;
    end
  end

  assign res_valid = s4_valid;
  assign res       = s4_res;

endmodule

`default_nettype wire

/* rtl/apfp_pack.sv */
`default_nettype none

module apfp_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  apfp_pkg::res_t    res,
  apfp_out_if.source        param_ch
);

  logic        valid;
  logic [15:0] param_id;
  logic [47:0] param_value;
  logic        parse_ok;
  logic [47:0] mag;
  logic [47:0] sat;
  logic [47:0] value_next;

  assign res_ready = !valid || param_ch.ready;

  // join whole and fraction, clamp, apply sign; zero when parse_ok is low
  always_comb begin
    mag = {1'b0, res.meta.whole, {apfp_pkg::FRAC_BITS{1'b0}}} + {31'b0, res.frac};
    sat = mag[47] ? apfp_pkg::VALUE_MAX : mag;
    if (!res.meta.ok) begin
      value_next = '0;
    end else if (res.meta.neg) begin
      value_next = 48'd0 - sat;
    end else begin
      value_next = sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      param_id    <= res.meta.id;
      param_value <= value_next;
      parse_ok    <= res.meta.ok;
    end
  end

  assign param_ch.valid       = valid;
  assign param_ch.param_id    = param_id;
  assign param_ch.param_value = param_value;
  assign param_ch.parse_ok    = parse_ok;

endmodule

`default_nettype wire

/* rtl/ascii_param_frame_parser_top.sv */
`default_nettype none
`include "assert_macros.svh"

// Parses ASCII parameter frames "#P<id>=<value>!" from a stream of UART bytes,
// one byte per transaction; a transaction with req_type set is a line error and
// drops any partial frame. Every '!' that closes the value of a frame yields one
// result: the decimal id (saturated at 65535), the value as signed Q31.16 with
// round-half-up on the fraction, and parse_ok, which is low with a zero value
// when the value text is not a well-formed number. A byte is taken every cycle
// unless the fraction path is stalled. On its way to the output register a result
// passes the fraction path: an input stage, a multiply that scales the fraction
// to nine digits, a reciprocal multiply that estimates the quotient by 10^9, a
// back multiply for the remainder, and a small fix-up of the quotient. The stages
// are elastic, so bytes keep flowing while a result waits at the output until
// all stages are full.
module ascii_param_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  apfp_in_if.sink    byte_ch,
  apfp_out_if.source param_ch
);

  logic            pkt_valid;
  logic            pkt_ready;
  apfp_pkg::pkt_t  pkt;
  logic            res_valid;
  logic            res_ready;
  apfp_pkg::res_t  res;

  // frame recognizer and number accumulator
  apfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

  // decimal fraction to binary
  apfp_frac u_frac (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // fixed-point assembly and output register
  apfp_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .param_ch  (param_ch)
  );

  // checks
  `ASSERT_ALWAYS(a_err_no_frame, !(byte_ch.valid && byte_ch.req_type && pkt_valid))
  `ASSERT_IMPLIES(a_bad_is_zero, param_ch.valid && !param_ch.parse_ok,
                  param_ch.param_value == 48'd0)
  `ASSERT_IMPLIES(a_no_min_value, param_ch.valid && param_ch.parse_ok,
                  param_ch.param_value != 48'h8000_0000_0000)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
  import apfp_pkg::*;

  // transaction kinds on the byte channel
  localparam logic REQ_BYTE     = 1'b0;
  localparam logic REQ_LINE_ERR = 1'b1;

  localparam int RANDOM_BYTES  = 1500;
  localparam int GAP_PCT       = 14;
  localparam int HOLD_AT_BYTE  = 600;
  localparam int HOLD_CYCLES   = 500;
  localparam int QUIET_FROM    = 1000;
  localparam int QUIET_TO      = 1400;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [2:0] {
    FP_IDLE, FP_HASH, FP_LETTER, FP_ID, FP_VALUE
  } frame_phase_e;

  typedef enum logic [2:0] {
    NUM_START, NUM_SIGN, NUM_WHOLE, NUM_FRAC, NUM_TRAIL, NUM_BAD
  } num_phase_e;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
  } uart_event_t;

  typedef struct packed {
    logic [15:0] id;
    logic [47:0] value;
    logic        ok;
  } param_result_t;

  logic clk = 1'b0;
  logic rst;

  apfp_in_if  byte_ch ();
  apfp_out_if param_ch ();

  ascii_param_frame_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .param_ch (param_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  uart_event_t   rx_stream[$];
  param_result_t results_due[$];
  param_result_t due_front;
  uart_event_t   next_event;

  int unsigned queued_total = 0;
  int unsigned bytes_taken  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned cycle_count  = 0;
  int unsigned fail_count   = 0;
  int unsigned mismatch_count = 0;

  // parser state mirror
  frame_phase_e fr_phase   = FP_IDLE;
  logic [15:0]  fr_id      = '0;
  int unsigned  val_chars  = 0;
  num_phase_e   num_phase  = NUM_START;
  bit           neg        = 1'b0;
  bit           seen       = 1'b0;
  logic [30:0]  whole      = '0;
  logic [31:0]  frac_acc   = '0;
  int unsigned  frac_cnt   = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_CR || c == CH_LF || c == CH_SPACE;
  endfunction

  task automatic clear_value();
    val_chars = 0;
    num_phase = NUM_START;
    neg       = 1'b0;
    seen      = 1'b0;
    whole     = '0;
    frac_acc  = '0;
    frac_cnt  = 0;
  endtask

  task automatic restart_frame();
    fr_phase = FP_IDLE;
    fr_id    = '0;
    clear_value();
  endtask

  // number syntax and accumulation for one value character
  task automatic absorb_value_char(logic [7:0] c);
    longint unsigned w_next;
    if (num_phase == NUM_BAD) begin
      num_phase = NUM_BAD;
    end else if (num_phase == NUM_TRAIL) begin
      if (!is_blank(c)) num_phase = NUM_BAD;
    end else if (is_blank(c)) begin
      num_phase = NUM_TRAIL;
    end else if (num_phase == NUM_FRAC) begin
      if (is_digit(c)) begin
        seen = 1'b1;
        if (frac_cnt < FRAC_DIGITS) begin
          frac_acc = frac_acc * 10 + 32'(c - CH_ZERO);
          frac_cnt++;
        end
      end else begin
        num_phase = NUM_BAD;
      end
    end else if (is_digit(c)) begin
      w_next = 64'(whole) * 10 + 64'(c - CH_ZERO);
      whole = (w_next > 64'(WHOLE_MAX)) ? WHOLE_MAX : w_next[30:0];
      seen = 1'b1;
      num_phase = NUM_WHOLE;
    end else if (c == CH_DOT) begin
      num_phase = NUM_FRAC;
    end else if (c == CH_MINUS && num_phase == NUM_START) begin
      neg = 1'b1;
      num_phase = NUM_SIGN;
    end else begin
      num_phase = NUM_BAD;
    end
  endtask

  // signed fixed point value with round-half-up fraction and saturation
  function automatic logic [47:0] fixed_value();
    longint unsigned den;
    longint unsigned frac_q;
    longint unsigned mag;
    den = 1;
    for (int k = 0; k < frac_cnt; k++) den = den * 10;
    frac_q = ((64'(frac_acc) << FRAC_BITS) + den / 2) / den;
    mag = (64'(whole) << FRAC_BITS) + frac_q;
    if (mag > 64'(VALUE_MAX)) mag = 64'(VALUE_MAX);
    if (neg) mag = 64'd0 - mag;
    return mag[47:0];
  endfunction

  // frame recognizer: one accepted transaction, zero or one result
  task automatic take_byte(logic req, logic [7:0] c);
    int unsigned   id_next;
    param_result_t res;
    if (req == REQ_LINE_ERR) begin
      restart_frame();
    end else begin
      case (fr_phase)
        FP_IDLE: begin
          if (c == CH_HASH) fr_phase = FP_HASH;
        end
        FP_HASH: begin
          if (c == CH_P) begin
            fr_phase = FP_LETTER;
            fr_id = '0;
          end else begin
            restart_frame();
          end
        end
        FP_LETTER, FP_ID: begin
          if (is_digit(c)) begin
            id_next = 32'(fr_id) * 10 + 32'(c - CH_ZERO);
            fr_id = (id_next > 32'(ID_MAX)) ? ID_MAX : id_next[15:0];
            fr_phase = FP_ID;
          end else if (c == CH_EQ) begin
            fr_phase = FP_VALUE;
            clear_value();
          end else begin
            restart_frame();
          end
        end
        FP_VALUE: begin
          if (c == CH_BANG) begin
            res.ok    = seen && (num_phase != NUM_BAD);
            res.id    = fr_id;
            res.value = res.ok ? fixed_value() : 48'd0;
            results_due.push_back(res);
            restart_frame();
          end else if (val_chars < VALUE_CHARS) begin
            val_chars++;
            absorb_value_char(c);
          end else begin
            restart_frame();
          end
        end
        default: restart_frame();
      endcase
    end
  endtask

  task automatic queue_char(logic [7:0] c);
    uart_event_t ev;
    ev.req  = REQ_BYTE;
    ev.data = c;
    rx_stream.push_back(ev);
    queued_total++;
  endtask

  task automatic queue_line_error();
    uart_event_t ev;
    ev.req  = REQ_LINE_ERR;
    ev.data = 8'($urandom_range(255));
    rx_stream.push_back(ev);
    queued_total++;
  endtask

  task automatic queue_text(string s);
    for (int k = 0; k < s.len(); k++) queue_char(s[k]);
  endtask

  // nines are favored so rounding carries and saturation come up
  function automatic logic [7:0] rand_digit();
    if ($urandom_range(3) == 0) return CH_NINE;
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(2))
      0:       return CH_CR;
      1:       return CH_LF;
      default: return CH_SPACE;
    endcase
  endfunction

  // mostly well-formed frames, some with broken header, value or ending
  task automatic queue_random_frame();
    int unsigned style;
    int unsigned id_len;
    int unsigned whole_len;
    int unsigned frac_len;
    style = $urandom_range(99);
    queue_char(CH_HASH);
    if (style < 4) queue_char(8'($urandom_range(255)));
    else queue_char(CH_P);
    id_len = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 3);
    repeat (id_len) queue_char(rand_digit());
    if (style >= 4 && style < 7) queue_char(8'($urandom_range(255)));
    queue_char(CH_EQ);
    if (style >= 7 && style < 12) begin
      // value around the length limit
      repeat ($urandom_range(VALUE_CHARS - 3, VALUE_CHARS + 3)) queue_char(rand_digit());
    end else begin
      if ($urandom_range(2) == 0) queue_char(CH_MINUS);
      whole_len = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
      repeat (whole_len) queue_char(rand_digit());
      if ($urandom_range(1) == 0) begin
        queue_char(CH_DOT);
        frac_len = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
        repeat (frac_len) queue_char(rand_digit());
      end
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) queue_char(rand_blank());
      if (style >= 12 && style < 20) queue_char(8'($urandom_range(255)));
    end
    if (style >= 20 && style < 23) queue_line_error();
    // a few frames are left open and run into the next one
    if (!(style >= 23 && style < 25)) queue_char(CH_BANG);
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count++;
    fail_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // byte driver and frame prediction on acceptance
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      restart_frame();
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        take_byte(byte_ch.req_type, byte_ch.rx_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (rx_stream.size() != 0 &&
            ((bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO) ||
             $urandom_range(99) >= GAP_PCT)) begin
          next_event = rx_stream.pop_front();
          byte_ch.valid    <= 1'b1;
          byte_ch.req_type <= next_event.req;
          byte_ch.rx_byte  <= next_event.data;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, so the pipeline backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AT_BYTE) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // result monitor and ready pacing
  always @(posedge clk) begin
    if (rst) begin
      param_ch.ready <= 1'b0;
    end else begin
      if (param_ch.valid && param_ch.ready) begin
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result: id %0d value %h ok %0b",
                                  param_ch.param_id, param_ch.param_value,
                                  param_ch.parse_ok));
        end else begin
          due_front = results_due.pop_front();
          if (param_ch.param_id !== due_front.id ||
              param_ch.param_value !== due_front.value ||
              param_ch.parse_ok !== due_front.ok) begin
            note_mismatch($sformatf(
              "mismatch: expected id %0d value %h ok %0b, got id %0d value %h ok %0b",
              due_front.id, due_front.value, due_front.ok, param_ch.param_id,
              param_ch.param_value, param_ch.parse_ok));
          end
        end
      end
      param_ch.ready <= (hold_left == 0) &&
                        ((bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO) ||
                         $urandom_range(99) >= GAP_PCT);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned directed_bytes;
    rst = 1'b1;
    byte_ch.valid    = 1'b0;
    byte_ch.req_type = REQ_BYTE;
    byte_ch.rx_byte  = '0;
    param_ch.ready   = 1'b0;

    // directed frames: field extremes and special cases
    queue_text("#P0=0!");
    queue_text("#P=1!");                              // empty id
    queue_text("#P99999=1.5!");                       // id saturates
    queue_text("#P65535=-4294967296!");               // whole part saturates
    queue_text("#P7=99999999999.9999999999!");        // extra fraction digits, full scale
    queue_text("#P1=-.5!");
    queue_text("#P2=-!");                             // sign only
    queue_text("#P3=.!");
    queue_text("#P4=!");                              // empty value
    queue_text("#P5=12 \r\n!");                       // trailing blanks
    queue_text("#P6=1 2!");                           // text after trailing blank
    queue_text("#P8=1.2.3!");
    queue_text("#P9=--1!");
    queue_text("#P10=1-!");
    queue_text("#P11=1234567890123456789012345678901!");   // value at the length limit
    queue_text("#P12=12345678901234567890123456789012!");  // one byte too long
    queue_text("#!#X#P1a=2!");                        // bad headers
    queue_text("#P#P1=1!");                           // hash after letter is not a new start
    queue_text("#P13=1");
    queue_line_error();                               // line error drops the frame
    queue_text("!#P14=0.000000001!#P15=-0.99999!#P16=3.14159265358!");
    queue_text("#P255=\r!#P256=-0!");
    queue_line_error();
    directed_bytes = queued_total;

    // random frames with noise and line errors between them
    while (queued_total < directed_bytes + RANDOM_BYTES) begin
      queue_random_frame();
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 4)) queue_char(8'($urandom_range(255)));
      if ($urandom_range(19) == 0) queue_line_error();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (rx_stream.size() != 0 || byte_ch.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
